@@ rtl/ubp_pkg.sv @@
package ubp_pkg;

  // Default buffer depths
  localparam int RX_DEPTH_DEF = 256;
  localparam int TX_DEPTH_DEF = 1024;

  // Field widths
  localparam int ACT_W  = 3;
  localparam int BYTE_W = 8;
  localparam int ERR_W  = 16;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 8;
  localparam int MODE_W = 2;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  // Event codes
  typedef enum logic [ACT_W-1:0] {
    ACT_RX    = 3'd0,
    ACT_READ  = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_TAKE  = 3'd3,
    ACT_ERROR = 3'd4,
    ACT_DELIV = 3'd5,
    ACT_PURGE = 3'd6
  } act_t;

  // Register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_PARITY   = 2'd0,
    CFG_RD_NOTIF = 2'd1,
    CFG_WR_NOTIF = 2'd2
  } cfg_idx_t;

  // Parity modes
  typedef enum logic [MODE_W-1:0] {
    PAR_NONE = 2'd0,
    PAR_ODD  = 2'd1,
    PAR_EVEN = 2'd2
  } par_mode_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
  } cmd_t;

endpackage

@@ rtl/ubp_ram.sv @@
module ubp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ubp_ctrl.sv @@
module ubp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  output logic          result_valid,
  input  logic          result_stall,
  output ubp_pkg::cmd_t cmd
);

  import ubp_pkg::*;

  state_t state, state_next;
  logic   out_full, out_full_next;

  // State and output-register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait until the result register is free or drains this cycle
        if (!out_full || !result_stall) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cmd.exec) begin
      out_full_next = 1'b1;
    end else if (!result_stall) begin
      out_full_next = 1'b0;
    end else begin
      out_full_next = out_full;
    end
  end

  assign item_stall   = (state != ST_IDLE);
  assign result_valid = out_full;

endmodule

@@ rtl/ubp_dp.sv @@
module ubp_dp #(
  parameter int RX_DEPTH = ubp_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = ubp_pkg::TX_DEPTH_DEF,
  parameter int RX_FW    = $clog2(RX_DEPTH + 1),
  parameter int TX_FW    = $clog2(TX_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ubp_pkg::cmd_t               cmd,
  input  logic [ubp_pkg::ACT_W-1:0]   action,
  input  logic [ubp_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        cfg_write,
  input  logic [ubp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [ubp_pkg::CFG_DW-1:0]  cfg_data,
  output logic [ubp_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_valid,
  output logic                        parity_bad,
  output logic                        rejected,
  output logic                        post_request,
  output logic                        readable_report,
  output logic                        writable_report,
  output logic [RX_FW-1:0]            rx_level,
  output logic [TX_FW-1:0]            tx_space,
  output logic [ubp_pkg::ERR_W-1:0]   error_total
);

  import ubp_pkg::*;

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  // Parity bit for the low seven bits of a byte
  function automatic logic parity_of(input logic [MODE_W-1:0] mode,
                                     input logic [BYTE_W-1:0] b);
    logic x;
    x = ^b[6:0];
    return (mode == PAR_ODD) ? ~x : x;
  endfunction

  // Configuration
  logic [MODE_W-1:0] parity_mode;
  logic              readable_notify;
  logic              writable_notify;

  // Latched item
  logic [ACT_W-1:0]  action_q;
  logic [BYTE_W-1:0] data_q;

  // FIFO and notification state
  logic [RX_AW-1:0] rx_head, rx_head_next;
  logic [RX_FW-1:0] rx_fill, rx_fill_next;
  logic [TX_AW-1:0] tx_head, tx_head_next;
  logic [TX_FW-1:0] tx_fill, tx_fill_next;
  logic [ERR_W-1:0] err_cnt, err_cnt_next;
  logic             rx_trig, rx_trig_next;
  logic             tx_trig, tx_trig_next;
  logic             pending, pending_next;

  // Step results
  logic [BYTE_W-1:0] ob;
  logic              valid_c, pbad_c, rej_c, preq_c, rrep_c, wrep_c;
  logic [ERR_W-1:0]  etotal_c;
  logic              post, deliver, par_on;

  // Memory ports
  logic [RX_FW:0]    rx_pos_sum, rx_pos;
  logic [TX_FW:0]    tx_pos_sum, tx_pos;
  logic              rx_we, tx_we;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata, tx_wdata;
  logic              rx_full, tx_full;
  logic [RX_AW-1:0]  rx_head_inc;
  logic [TX_AW-1:0]  tx_head_inc;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      parity_mode     <= PAR_NONE;
      readable_notify <= 1'b0;
      writable_notify <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PARITY:   parity_mode     <= cfg_data[MODE_W-1:0];
        CFG_RD_NOTIF: readable_notify <= cfg_data[0];
        CFG_WR_NOTIF: writable_notify <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_q <= action;
      data_q   <= data_byte;
    end
  end

  // Tail positions with wrap
  assign rx_pos_sum = {{(RX_FW + 1 - RX_AW){1'b0}}, rx_head} + {1'b0, rx_fill};
  assign rx_pos     = (rx_pos_sum >= (RX_FW + 1)'(RX_DEPTH)) ?
                      rx_pos_sum - (RX_FW + 1)'(RX_DEPTH) : rx_pos_sum;
  assign tx_pos_sum = {{(TX_FW + 1 - TX_AW){1'b0}}, tx_head} + {1'b0, tx_fill};
  assign tx_pos     = (tx_pos_sum >= (TX_FW + 1)'(TX_DEPTH)) ?
                      tx_pos_sum - (TX_FW + 1)'(TX_DEPTH) : tx_pos_sum;

  assign rx_full = (rx_fill == RX_FW'(RX_DEPTH));
  assign tx_full = (tx_fill == TX_FW'(TX_DEPTH));
  assign par_on  = (parity_mode == PAR_ODD) || (parity_mode == PAR_EVEN);

  assign rx_head_inc = (rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head + RX_AW'(1);
  assign tx_head_inc = (tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head + TX_AW'(1);

  assign tx_wdata = par_on ? {parity_of(parity_mode, data_q), data_q[6:0]} : data_q;
  assign rx_we    = cmd.exec && (action_q == ACT_RX) && !rx_full;
  assign tx_we    = cmd.exec && (action_q == ACT_WRITE) && !tx_full;

  // FIFO storage, read continuously at the head
  ubp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_pos[RX_AW-1:0]),
    .wdata (data_q),
    .raddr (rx_head),
    .rdata (rx_rdata)
  );

  ubp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_pos[TX_AW-1:0]),
    .wdata (tx_wdata),
    .raddr (tx_head),
    .rdata (tx_rdata)
  );

  // Step the event
  always_comb begin
    rx_head_next = rx_head;
    rx_fill_next = rx_fill;
    tx_head_next = tx_head;
    tx_fill_next = tx_fill;
    err_cnt_next = err_cnt;
    rx_trig_next = rx_trig;
    tx_trig_next = tx_trig;
    pending_next = pending;
    ob           = '0;
    valid_c      = 1'b0;
    pbad_c       = 1'b0;
    rej_c        = 1'b0;
    preq_c       = 1'b0;
    rrep_c       = 1'b0;
    wrep_c       = 1'b0;
    post         = 1'b0;
    deliver      = 1'b0;
    case (action_q)
      ACT_RX: begin
        if (rx_full) begin
          // drop the byte and count it
          if (err_cnt != ERR_MAX) begin
            err_cnt_next = err_cnt + ERR_W'(1);
          end
          post = 1'b1;
        end else begin
          rx_fill_next = rx_fill + RX_FW'(1);
          if (readable_notify && !rx_trig) begin
            rx_trig_next = 1'b1;
            post         = 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (rx_fill == '0) begin
          rej_c = 1'b1;
        end else begin
          if (par_on) begin
            pbad_c = (rx_rdata[7] != parity_of(parity_mode, rx_rdata));
            ob     = {1'b0, rx_rdata[6:0]};
          end else begin
            ob = rx_rdata;
          end
          valid_c      = 1'b1;
          rx_head_next = rx_head_inc;
          rx_fill_next = rx_fill - RX_FW'(1);
        end
      end
      ACT_WRITE: begin
        if (tx_full) begin
          rej_c = 1'b1;
        end else begin
          tx_fill_next = tx_fill + TX_FW'(1);
        end
      end
      ACT_TAKE: begin
        if (tx_fill != '0) begin
          ob           = tx_rdata;
          valid_c      = 1'b1;
          tx_head_next = tx_head_inc;
          tx_fill_next = tx_fill - TX_FW'(1);
          // drained: raise the writable trigger once
          if (tx_fill == TX_FW'(1) && writable_notify && !tx_trig) begin
            tx_trig_next = 1'b1;
            post         = 1'b1;
          end
        end
      end
      ACT_ERROR: begin
        if (err_cnt != ERR_MAX) begin
          err_cnt_next = err_cnt + ERR_W'(1);
        end
        post = 1'b1;
      end
      ACT_DELIV: begin
        deliver      = 1'b1;
        pending_next = 1'b0;
        rrep_c       = rx_trig && (rx_fill != '0);
        wrep_c       = tx_trig && (tx_fill == '0);
        rx_trig_next = 1'b0;
        tx_trig_next = 1'b0;
      end
      ACT_PURGE: begin
        tx_head_next = '0;
        tx_fill_next = '0;
      end
      default: begin
      end
    endcase
    // one outstanding post at a time
    if (post && !pending) begin
      pending_next = 1'b1;
      preq_c       = 1'b1;
    end
    etotal_c = err_cnt_next;
    if (deliver) begin
      err_cnt_next = '0;
    end
  end

  // Commit state on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head <= '0;
      rx_fill <= '0;
      tx_head <= '0;
      tx_fill <= '0;
      err_cnt <= '0;
      rx_trig <= 1'b0;
      tx_trig <= 1'b0;
      pending <= 1'b0;
    end else if (cmd.exec) begin
      rx_head <= rx_head_next;
      rx_fill <= rx_fill_next;
      tx_head <= tx_head_next;
      tx_fill <= tx_fill_next;
      err_cnt <= err_cnt_next;
      rx_trig <= rx_trig_next;
      tx_trig <= tx_trig_next;
      pending <= pending_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_byte        <= ob;
      out_valid       <= valid_c;
      parity_bad      <= pbad_c;
      rejected        <= rej_c;
      post_request    <= preq_c;
      readable_report <= rrep_c;
      writable_report <= wrep_c;
      rx_level        <= rx_fill_next;
      tx_space        <= TX_FW'(TX_DEPTH) - tx_fill_next;
      error_total     <= etotal_c;
    end
  end

endmodule

@@ rtl/uart_buffer_with_seven_bit_parity.sv @@
// An accepted item executes in the EXEC state, which registers its result;
// execution waits there while an earlier result is stalled.
// The controller takes an item, then executes it once the FIFO memory's
// registered head read is back; item_stall holds off new items until then.
// A stalled result holds the executing item, and no next item is taken.
// Reset (synchronous) clears pointers, fill counts, error counter, triggers,
// post flag, config registers; FIFO contents are not cleared, no clearing pass.
module uart_buffer_with_seven_bit_parity #(
  parameter int RX_DEPTH = ubp_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = ubp_pkg::TX_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [ubp_pkg::ACT_W-1:0]            action,
  input  logic [ubp_pkg::BYTE_W-1:0]           data_byte,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [ubp_pkg::BYTE_W-1:0]           out_byte,
  output logic                                 out_valid,
  output logic                                 parity_bad,
  output logic                                 rejected,
  output logic                                 post_request,
  output logic                                 readable_report,
  output logic                                 writable_report,
  output logic [$clog2(RX_DEPTH + 1)-1:0]      rx_level,
  output logic [$clog2(TX_DEPTH + 1)-1:0]      tx_space,
  output logic [ubp_pkg::ERR_W-1:0]            error_total,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ubp_pkg::CFG_IW-1:0]           cfg_index,
  input  logic [ubp_pkg::CFG_DW-1:0]           cfg_data
);

  import ubp_pkg::*;

  cmd_t cmd;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  ubp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  ubp_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .action          (action),
    .data_byte       (data_byte),
    .cfg_write       (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_byte        (out_byte),
    .out_valid       (out_valid),
    .parity_bad      (parity_bad),
    .rejected        (rejected),
    .post_request    (post_request),
    .readable_report (readable_report),
    .writable_report (writable_report),
    .rx_level        (rx_level),
    .tx_space        (tx_space),
    .error_total     (error_total)
  );

endmodule
